/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL. Every macro samples on clk_i and is
// disabled while rst_ni is low, so it must be used inside a module that has
// both of those ports.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define MAFHS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// The expression must never be true.
`define MAFHS_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

/* rtl/core/mafhs_pkg.sv */
`timescale 1ns / 1ps
package mafhs_pkg;

  localparam int unsigned FIFO_DEPTH_DEF = 2;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic [0:0]  REG_SEARCH_LIMIT = 1'b0;
  localparam logic [15:0] SEARCH_LIMIT_RST = 16'd10000;

  localparam logic [10:0] SYNC_WORD = 11'h7FF;

  localparam logic [1:0] VER_RESERVED    = 2'd1;
  localparam logic [1:0] VER_MPEG1       = 2'd3;
  localparam logic [1:0] LAYER_BITS_NONE = 2'd0;
  localparam logic [1:0] LAYER_NONE      = 2'd0;
  localparam logic [1:0] LAYER_I         = 2'd1;
  localparam logic [3:0] BR_IDX_FREE     = 4'd0;
  localparam logic [3:0] BR_IDX_BAD      = 4'd15;
  localparam logic [1:0] SR_IDX_RESERVED = 2'd3;
  localparam logic [1:0] EMPH_RESERVED   = 2'd2;

  // Frame length numerator: constant times kbps, at most 144000 * 384.
  localparam int unsigned NUM_W     = 26;
  localparam logic [17:0] K_LAYER1  = 18'd12000;
  localparam logic [17:0] K_LAYER23 = 18'd144000;

  typedef enum logic [1:0] {
    ST_VALID   = 2'd0,
    ST_INVALID = 2'd1,
    ST_LIMIT   = 2'd2
  } status_e;

  typedef struct packed {
    logic        limit;
    logic [31:0] window;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  localparam logic [8:0] BR_MPEG1 [0:2][0:15] = '{
    '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
      9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
    '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
      9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0}
  };

  localparam logic [8:0] BR_MPEG2 [0:1][0:15] = '{
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
    '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
      9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
  };

  localparam logic [15:0] SR_TABLE [0:3][0:2] = '{
    '{16'd11025, 16'd12000, 16'd8000},
    '{16'd0, 16'd0, 16'd0},
    '{16'd22050, 16'd24000, 16'd16000},
    '{16'd44100, 16'd48000, 16'd32000}
  };

  function automatic logic [8:0] bitrate_lookup(input logic [1:0] ver,
                                                input logic [1:0] layer,
                                                input logic [3:0] idx);
    logic [8:0] br;
    br = '0;
    if (layer != LAYER_NONE) begin
      if (ver == VER_MPEG1) begin
        br = BR_MPEG1[layer - 2'd1][idx];
      end else begin
        br = BR_MPEG2[(layer == LAYER_I) ? 1'b0 : 1'b1][idx];
      end
    end
    return br;
  endfunction

  function automatic logic [15:0] sample_rate_lookup(input logic [1:0] ver,
                                                     input logic [1:0] sri);
    logic [15:0] sr;
    sr = '0;
    if (sri != SR_IDX_RESERVED) begin
      sr = SR_TABLE[ver][sri];
    end
    return sr;
  endfunction

endpackage

/* rtl/core/mafhs_in_if.sv */
`timescale 1ns / 1ps
interface mafhs_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink (input valid, input kind, input data_byte, output ready);
endinterface

/* rtl/core/mafhs_out_if.sv */
`timescale 1ns / 1ps
interface mafhs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [1:0]  version_code;
  logic [1:0]  layer;
  logic        crc_bit;
  logic [8:0]  bitrate_kbps;
  logic [15:0] sample_rate_hz;
  logic [11:0] frame_bytes;
  logic [1:0]  channel_mode;
  logic        copyright_bit;
  logic        original_bit;
  logic [1:0]  emphasis;

  modport source (output valid, output status, output version_code, output layer,
                  output crc_bit, output bitrate_kbps, output sample_rate_hz,
                  output frame_bytes, output channel_mode, output copyright_bit,
                  output original_bit, output emphasis, input ready);
  modport sink (input valid, input status, input version_code, input layer,
                input crc_bit, input bitrate_kbps, input sample_rate_hz,
                input frame_bytes, input channel_mode, input copyright_bit,
                input original_bit, input emphasis, output ready);
endinterface

/* rtl/core/mpeg_audio_frame_header_sync_unit.sv */
// Port      Dir   Protocol       Contents
// in_i      in    valid/ready    kind, data_byte: one file byte or a restart
// out_o     out   valid/ready    decoded header, or a search-exhausted report
// apb       in    APB slave      search_limit at byte address 0
//
// The front takes one byte per cycle and only stalls when the job queue is full.
// A found header passes through the back in steps: table lookup, one multiply,
// then a 26-step restoring division for the frame length, one bit per cycle.
// A search-exhausted job or a header with zero bitrate or rate skips the divide.
// Reset clears the window, counters and queue and sets search_limit to 10000.
// A result waiting on out_o stalls the back; bytes keep flowing in until the queue is full.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mpeg_audio_frame_header_sync_unit #(
  parameter int unsigned FIFO_DEPTH = mafhs_pkg::FIFO_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  mafhs_in_if.sink                         in_i,
  mafhs_out_if.source                      out_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mafhs_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mafhs_pkg::APB_DATA_W-1:0] pwdata,
  output logic [mafhs_pkg::APB_DATA_W-1:0] prdata,
  output logic                             pready
);
  import mafhs_pkg::*;

  logic [15:0] limit_q;
  logic        reg_hit;
  push_t       push;
  job_t        head_job;
  fifo_stat_t  fifo_stat;
  logic        pop;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_SEARCH_LIMIT);
  assign prdata  = reg_hit ? {{(APB_DATA_W - 16){1'b0}}, limit_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= SEARCH_LIMIT_RST;
    end else if (psel && penable && pwrite && reg_hit) begin
      limit_q <= pwdata[15:0];
    end
  end

  mafhs_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_i           (in_i),
    .search_limit_i (limit_q),
    .fifo_stat_i    (fifo_stat),
    .push_o         (push)
  );

  mafhs_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .data_o (head_job),
    .stat_o (fifo_stat)
  );

  mafhs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .fifo_stat_i (fifo_stat),
    .pop_o       (pop),
    .out_o       (out_o)
  );

  `MAFHS_ASSERT_IMPL(a_push_room, push.valid, !fifo_stat.full, "job pushed into a full queue")
  `MAFHS_ASSERT_IMPL(a_restart_quiet, in_i.valid && in_i.ready && in_i.kind, !push.valid, "restart produced a job")
  `MAFHS_ASSERT_IMPL(a_limit_zero, out_o.valid && out_o.status == ST_LIMIT, out_o.bitrate_kbps == '0 && out_o.sample_rate_hz == '0 && out_o.frame_bytes == '0, "exhausted result carries data")
  `MAFHS_ASSERT_IMPL(a_valid_rates, out_o.valid && out_o.status == ST_VALID, out_o.bitrate_kbps != '0 && out_o.sample_rate_hz != '0, "valid header with zero rate")
  `MAFHS_ASSERT_NEVER(a_fifo_flags, fifo_stat.full && fifo_stat.empty, "queue full and empty at once")

endmodule

/* rtl/core/mafhs_front.sv */
`timescale 1ns / 1ps
module mafhs_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  mafhs_in_if.sink               in_i,
  input  logic [15:0]            search_limit_i,
  input  mafhs_pkg::fifo_stat_t  fifo_stat_i,
  output mafhs_pkg::push_t       push_o
);
  import mafhs_pkg::*;

  localparam logic [2:0] FILL_FULL = 3'd4;
  localparam logic [2:0] FILL_LAST = 3'd3;

  logic [31:0] window_q, window_d;
  logic [2:0]  fill_q, fill_d;
  logic [15:0] miss_q, miss_d;
  logic        done_q, done_d;
  logic        accept;
  logic [31:0] shifted;

  assign in_i.ready = !fifo_stat_i.full;
  assign accept     = in_i.valid && in_i.ready;
  assign shifted    = {window_q[23:0], in_i.data_byte};

  always_comb begin
    window_d          = window_q;
    fill_d            = fill_q;
    miss_d            = miss_q;
    done_d            = done_q;
    push_o.valid      = 1'b0;
    push_o.job.limit  = 1'b0;
    push_o.job.window = shifted;
    if (accept) begin
      if (in_i.kind) begin
        window_d = '0;
        fill_d   = '0;
        miss_d   = '0;
        done_d   = 1'b0;
      end else if (!done_q) begin
        window_d = shifted;
        if (fill_q != FILL_FULL) begin
          fill_d = fill_q + 3'd1;
        end
        // The window holds four bytes once this byte is in.
        if (fill_q >= FILL_LAST) begin
          if (shifted[31:21] == SYNC_WORD) begin
            push_o.valid = 1'b1;
            done_d       = 1'b1;
          end else if (miss_q >= search_limit_i) begin
            push_o.valid     = 1'b1;
            push_o.job.limit = 1'b1;
            done_d           = 1'b1;
          end else begin
            miss_d = miss_q + 16'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      fill_q   <= '0;
      miss_q   <= '0;
      done_q   <= 1'b0;
    end else begin
      window_q <= window_d;
      fill_q   <= fill_d;
      miss_q   <= miss_d;
      done_q   <= done_d;
    end
  end

endmodule

/* rtl/core/mafhs_fifo.sv */
`timescale 1ns / 1ps
module mafhs_fifo #(
  parameter int unsigned DEPTH = mafhs_pkg::FIFO_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mafhs_pkg::push_t       push_i,
  input  logic                   pop_i,
  output mafhs_pkg::job_t        data_o,
  output mafhs_pkg::fifo_stat_t  stat_o
);
  import mafhs_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign stat_o.full  = (count_q == CNT_FULL);
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i.valid && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* rtl/core/mafhs_back.sv */
`timescale 1ns / 1ps
module mafhs_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mafhs_pkg::job_t        job_i,
  input  mafhs_pkg::fifo_stat_t  fifo_stat_i,
  output logic                   pop_o,
  mafhs_out_if.source            out_o
);
  import mafhs_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W);
  localparam logic [CNT_W-1:0] CNT_START = CNT_W'(NUM_W - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MULT,
    S_DIV,
    S_SEND
  } state_e;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  version_code;
    logic [1:0]  layer;
    logic        crc_bit;
    logic [8:0]  bitrate_kbps;
    logic [15:0] sample_rate_hz;
    logic [11:0] frame_bytes;
    logic [1:0]  channel_mode;
    logic        copyright_bit;
    logic        original_bit;
    logic [1:0]  emphasis;
  } res_t;

  state_e           state_q, state_d;
  job_t             job_q, job_d;
  res_t             res_q, res_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [15:0]      rem_q, rem_d;
  logic [11:0]      quo_q, quo_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [1:0]  ver;
  logic [1:0]  lbits;
  logic [3:0]  bri;
  logic [1:0]  sri;
  logic        pad;
  logic [1:0]  emph;
  logic [1:0]  layer;
  logic [8:0]  br;
  logic [15:0] sr;
  logic        hdr_ok;
  logic        layer1;
  logic [17:0] kmul;
  logic [26:0] prod;
  logic [16:0] rem_sh;
  logic [16:0] rem_diff;
  logic        qbit;
  logic [11:0] quo_next;

  assign ver    = job_q.window[20:19];
  assign lbits  = job_q.window[18:17];
  assign bri    = job_q.window[15:12];
  assign sri    = job_q.window[11:10];
  assign pad    = job_q.window[9];
  assign emph   = job_q.window[1:0];
  // Layer bits 1, 2, 3 stand for layers 3, 2, 1.
  assign layer  = (lbits == LAYER_BITS_NONE) ? LAYER_NONE : 2'(3'd4 - {1'b0, lbits});
  assign br     = bitrate_lookup(ver, layer, bri);
  assign sr     = sample_rate_lookup(ver, sri);
  assign hdr_ok = (ver != VER_RESERVED) && (lbits != LAYER_BITS_NONE) &&
                  (bri != BR_IDX_FREE) && (bri != BR_IDX_BAD) &&
                  (sri != SR_IDX_RESERVED) && (emph != EMPH_RESERVED);

  assign layer1   = (res_q.layer == LAYER_I);
  assign kmul     = layer1 ? K_LAYER1 : K_LAYER23;
  assign prod     = kmul * res_q.bitrate_kbps;
  assign rem_sh   = {rem_q, num_q[NUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, res_q.sample_rate_hz};
  assign qbit     = (rem_sh >= {1'b0, res_q.sample_rate_hz});
  // Only the low quotient bits reach the 12-bit frame length.
  assign quo_next = {quo_q[10:0], qbit};

  assign out_o.valid          = (state_q == S_SEND);
  assign out_o.status         = res_q.status;
  assign out_o.version_code   = res_q.version_code;
  assign out_o.layer          = res_q.layer;
  assign out_o.crc_bit        = res_q.crc_bit;
  assign out_o.bitrate_kbps   = res_q.bitrate_kbps;
  assign out_o.sample_rate_hz = res_q.sample_rate_hz;
  assign out_o.frame_bytes    = res_q.frame_bytes;
  assign out_o.channel_mode   = res_q.channel_mode;
  assign out_o.copyright_bit  = res_q.copyright_bit;
  assign out_o.original_bit   = res_q.original_bit;
  assign out_o.emphasis       = res_q.emphasis;

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    res_d   = res_q;
    num_d   = num_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    pop_o   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (!fifo_stat_i.empty) begin
          pop_o   = 1'b1;
          job_d   = job_i;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        res_d.status         = hdr_ok ? ST_VALID : ST_INVALID;
        res_d.version_code   = ver;
        res_d.layer          = layer;
        res_d.crc_bit        = job_q.window[16];
        res_d.bitrate_kbps   = br;
        res_d.sample_rate_hz = sr;
        res_d.frame_bytes    = '0;
        res_d.channel_mode   = job_q.window[7:6];
        res_d.copyright_bit  = job_q.window[3];
        res_d.original_bit   = job_q.window[2];
        res_d.emphasis       = emph;
        if (job_q.limit) begin
          res_d        = '0;
          res_d.status = ST_LIMIT;
          state_d      = S_SEND;
        end else if (br == '0 || sr == '0) begin
          state_d = S_SEND;
        end else begin
          state_d = S_MULT;
        end
      end
      S_MULT: begin
        num_d   = prod[NUM_W-1:0];
        rem_d   = '0;
        quo_d   = '0;
        cnt_d   = CNT_START;
        state_d = S_DIV;
      end
      S_DIV: begin
        // One restoring division step per cycle, numerator MSB first.
        rem_d = qbit ? rem_diff[15:0] : rem_sh[15:0];
        num_d = {num_q[NUM_W-2:0], 1'b0};
        quo_d = quo_next;
        if (cnt_q == '0) begin
          if (layer1) begin
            res_d.frame_bytes = {quo_next[9:0] + {9'b0, pad}, 2'b00};
          end else begin
            res_d.frame_bytes = quo_next + {11'b0, pad};
          end
          state_d = S_SEND;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_SEND: begin
        if (out_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      job_q   <= '0;
      res_q   <= '0;
      num_q   <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
      res_q   <= res_d;
      num_q   <= num_d;
      rem_q   <= rem_d;
      quo_q   <= quo_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

/* tb/sv/mpeg_audio_frame_header_sync_unit_tb.sv */
`timescale 1ns / 1ps
module mpeg_audio_frame_header_sync_unit_tb;
  import mafhs_pkg::*;

  localparam int unsigned CLK_HALF_NS     = 5;
  localparam int unsigned RESET_CYCLES    = 10;
  localparam int unsigned DRAIN_CYCLES    = 64;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned END_WAIT_CYCLES = 20000;
  localparam int unsigned ITEM_TARGET     = 950;
  localparam int unsigned PHASE_QUOTA     = 185;
  localparam int unsigned PRESSURE_RUNS   = 12;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  localparam int unsigned UNUSED_REG_IDX = 1;
  localparam logic [APB_ADDR_W-1:0] LIMIT_ADDR  = APB_ADDR_W'(4 * REG_SEARCH_LIMIT);
  localparam logic [APB_ADDR_W-1:0] UNUSED_ADDR = APB_ADDR_W'(4 * UNUSED_REG_IDX);

  localparam logic [15:0] LIMIT_AT_RESET = 16'd10000;
  localparam int unsigned LAYER1_SCALE   = 12000;
  localparam int unsigned LAYER23_SCALE  = 144000;

  localparam int unsigned KBPS_V1 [3][16] = '{
    '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
    '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
    '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0}
  };
  localparam int unsigned KBPS_V2 [2][16] = '{
    '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0},
    '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0}
  };
  localparam int unsigned RATE_HZ [4][3] = '{
    '{11025, 12000, 8000},
    '{0, 0, 0},
    '{22050, 24000, 16000},
    '{44100, 48000, 32000}
  };

  typedef struct packed {
    status_e     status;
    logic [1:0]  version_code;
    logic [1:0]  layer;
    logic        crc_bit;
    logic [8:0]  bitrate_kbps;
    logic [15:0] sample_rate_hz;
    logic [11:0] frame_bytes;
    logic [1:0]  channel_mode;
    logic        copyright_bit;
    logic        original_bit;
    logic [1:0]  emphasis;
  } hdr_result_t;

  class frame_header_scoreboard;
    logic [15:0]  limit = LIMIT_AT_RESET;
    logic [31:0]  window = '0;
    int unsigned  fill = 0;
    logic [15:0]  misses = '0;
    bit           done = 1'b0;
    hdr_result_t  pending_headers[$];
    int unsigned  errors = 0;

    function void clear_search();
      window = '0;
      fill = 0;
      misses = '0;
      done = 1'b0;
    endfunction

    function void write_reg(int unsigned idx, logic [31:0] value);
      if (idx == REG_SEARCH_LIMIT) begin
        limit = value[15:0];
      end
    endfunction

    function int unsigned pending();
      return pending_headers.size();
    endfunction

    function hdr_result_t decode_header(logic [31:0] h);
      hdr_result_t r;
      logic [1:0]  ver;
      logic [1:0]  lbits;
      logic [3:0]  bri;
      logic [1:0]  sri;
      int unsigned lay;
      int unsigned kbps;
      int unsigned hz;
      int unsigned len;
      bit          ok;
      ver = h[20:19];
      lbits = h[18:17];
      bri = h[15:12];
      sri = h[11:10];
      lay = (lbits == LAYER_BITS_NONE) ? 0 : 4 - lbits;
      kbps = 0;
      hz = 0;
      len = 0;
      if (lay != 0) begin
        if (ver == VER_MPEG1) begin
          kbps = KBPS_V1[lay - 1][bri];
        end else begin
          kbps = KBPS_V2[(lay == 1) ? 0 : 1][bri];
        end
      end
      if (sri != SR_IDX_RESERVED) begin
        hz = RATE_HZ[ver][sri];
      end
      if (kbps != 0 && hz != 0) begin
        if (lay == 1) begin
          len = (LAYER1_SCALE * kbps / hz + h[9]) * 4;
        end else begin
          len = LAYER23_SCALE * kbps / hz + h[9];
        end
      end
      ok = ver != VER_RESERVED && lbits != LAYER_BITS_NONE && bri != BR_IDX_FREE &&
           bri != BR_IDX_BAD && sri != SR_IDX_RESERVED && h[1:0] != EMPH_RESERVED;
      r.status = ok ? ST_VALID : ST_INVALID;
      r.version_code = ver;
      r.layer = 2'(lay);
      r.crc_bit = h[16];
      r.bitrate_kbps = 9'(kbps);
      r.sample_rate_hz = 16'(hz);
      r.frame_bytes = 12'(len);
      r.channel_mode = h[7:6];
      r.copyright_bit = h[3];
      r.original_bit = h[2];
      r.emphasis = h[1:0];
      return r;
    endfunction

    // Returns 0 when the block simply drops the item.
    function bit note_input(logic kind, logic [7:0] data_byte);
      hdr_result_t r;
      if (kind == KIND_RESTART) begin
        clear_search();
        return 1'b1;
      end
      if (done) begin
        return 1'b0;
      end
      window = {window[23:0], data_byte};
      if (fill < 4) begin
        fill++;
      end
      if (fill < 4) begin
        return 1'b1;
      end
      if (window[31:21] == SYNC_WORD) begin
        pending_headers.push_back(decode_header(window));
        done = 1'b1;
      end else if (misses >= limit) begin
        r = '0;
        r.status = ST_LIMIT;
        pending_headers.push_back(r);
        done = 1'b1;
      end else begin
        misses++;
      end
      return 1'b1;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(hdr_result_t got);
      hdr_result_t want;
      if (pending_headers.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        return;
      end
      want = pending_headers.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("version_code", want.version_code, got.version_code);
      compare_field("layer", want.layer, got.layer);
      compare_field("crc_bit", want.crc_bit, got.crc_bit);
      compare_field("bitrate_kbps", want.bitrate_kbps, got.bitrate_kbps);
      compare_field("sample_rate_hz", want.sample_rate_hz, got.sample_rate_hz);
      compare_field("frame_bytes", want.frame_bytes, got.frame_bytes);
      compare_field("channel_mode", want.channel_mode, got.channel_mode);
      compare_field("copyright_bit", want.copyright_bit, got.copyright_bit);
      compare_field("original_bit", want.original_bit, got.original_bit);
      compare_field("emphasis", want.emphasis, got.emphasis);
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  mafhs_in_if  in_if ();
  mafhs_out_if out_if ();

  frame_header_scoreboard sb = new;

  int unsigned items_counted = 0;
  bit          src_burst = 1'b0;
  bit          sink_burst = 1'b0;
  bit          hold_req = 1'b0;

  mpeg_audio_frame_header_sync_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk_i = 1'b0;
    #(CLK_HALF_NS);
    clk_i = 1'b1;
    #(CLK_HALF_NS);
  end

  function automatic int unsigned idle_len(bit burst);
    int unsigned r;
    r = $urandom_range(99);
    if (burst || r < 55) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Sync bits forced; most headers get legal fields so the decode path is exercised.
  function automatic logic [31:0] random_header();
    logic [31:0] h;
    h = $urandom();
    h[31:21] = SYNC_WORD;
    if ($urandom_range(99) < 60) begin
      if (h[20:19] == VER_RESERVED) begin
        h[20:19] = VER_MPEG1;
      end
      if (h[18:17] == LAYER_BITS_NONE) begin
        h[18:17] = 2'($urandom_range(1, 3));
      end
      if (h[15:12] == BR_IDX_FREE || h[15:12] == BR_IDX_BAD) begin
        h[15:12] = 4'($urandom_range(1, 14));
      end
      if (h[11:10] == SR_IDX_RESERVED) begin
        h[11:10] = 2'($urandom_range(0, 2));
      end
      if (h[1:0] == EMPH_RESERVED) begin
        h[1:0] = 2'd0;
      end
    end
    return h;
  endfunction

  // Called and returns at a falling edge.
  task automatic send_item(input logic kind, input logic [7:0] data_byte);
    int unsigned gap;
    gap = idle_len(src_burst);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.kind = kind;
    in_if.data_byte = data_byte;
    do @(posedge clk_i); while (!in_if.ready);
    void'(sb.note_input(kind, data_byte));
    items_counted++;
    @(negedge clk_i);
  endtask

  task automatic send_header(input logic [31:0] h);
    for (int i = 0; i < 4; i++) begin
      send_item(KIND_DATA, h[31 - 8 * i -: 8]);
    end
  endtask

  task automatic send_noise(input int unsigned count);
    repeat (count) send_item(KIND_DATA, 8'($urandom()));
  endtask

  task automatic wait_idle();
    in_if.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(addr >> 2, value);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic apb_check_limit();
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = LIMIT_ADDR;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {16'h0, sb.limit}) begin
      sb.errors++;
      $display("%0t: search_limit readback mismatch, expected %0d, actual %0d",
               $time, sb.limit, prdata);
    end
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_limit(input logic [15:0] value);
    wait_idle();
    apb_write(LIMIT_ADDR, {16'h0, value});
    apb_check_limit();
  endtask

  // One search attempt; the restart is sometimes skipped so a search can
  // carry over into the next one, including across a limit change.
  task automatic random_search();
    int unsigned pick;
    int unsigned n;
    logic [31:0] h;
    src_burst = ($urandom_range(9) == 0);
    if ($urandom_range(9) != 0) begin
      send_item(KIND_RESTART, 8'($urandom()));
    end
    pick = $urandom_range(99);
    h = random_header();
    if (pick < 70) begin
      send_noise($urandom_range(0, 6));
      send_header(h);
      send_noise($urandom_range(0, 2));
    end else if (pick < 85) begin
      send_noise($urandom_range(1, 40));
    end else begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
        send_item(KIND_DATA, h[31 - 8 * i -: 8]);
      end
    end
  endtask

  task automatic run_phase(input logic [15:0] value);
    int unsigned start;
    set_limit(value);
    start = items_counted;
    while (items_counted - start < PHASE_QUOTA && items_counted < ITEM_TARGET) begin
      random_search();
    end
  endtask

  task automatic pressure_burst();
    wait_idle();
    src_burst = 1'b1;
    hold_req = 1'b1;
    repeat (PRESSURE_RUNS) begin
      send_item(KIND_RESTART, 8'($urandom()));
      send_header(random_header());
    end
  endtask

  task automatic directed_items();
    // Valid MPEG-1 layer III header; the byte after it must be dropped.
    send_header(32'hFFFB_9064);
    send_item(KIND_DATA, 8'hFF);
    send_item(KIND_RESTART, 8'hFF);
    // One miss, then sync with every header field in a reserved or illegal state.
    send_item(KIND_DATA, 8'h00);
    send_header(32'hFFE9_F3FE);
    send_item(KIND_RESTART, 8'h00);
    send_header(32'hFFFF_FFFF);
    send_item(KIND_RESTART, 8'h5A);
    // Lower the limit in the middle of a search that already has one miss.
    set_limit(16'd2);
    send_header(32'h0000_0000);
    set_limit(16'd1);
    send_item(KIND_DATA, 8'h00);
    send_item(KIND_RESTART, 8'hA5);
    // A write outside the register map must leave the limit alone.
    wait_idle();
    apb_write(UNUSED_ADDR, 32'h0000_BEEF);
    apb_check_limit();
    set_limit(16'd0);
    send_header(32'h1234_5678);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.kind = KIND_DATA;
    in_if.data_byte = '0;
    out_if.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
  end

  initial begin : stimulus
    int unsigned waited;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    directed_items();
    run_phase(16'd65535);
    run_phase(16'd7);
    pressure_burst();
    run_phase(16'd0);
    run_phase(16'($urandom_range(1, 30)));
    run_phase(LIMIT_AT_RESET);
    while (items_counted < ITEM_TARGET) begin
      random_search();
    end
    in_if.valid = 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < END_WAIT_CYCLES) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
    end
    if (sb.errors == 0) begin
      $display("mpeg_audio_frame_header_sync_unit verification clean");
    end else begin
      $display("mpeg_audio_frame_header_sync_unit verification failed");
    end
    $finish;
  end

  // Output side: random stalls, plus one long hold-off on request so the
  // job queue fills up and the input stalls.
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      if (stall_left > 0) begin
        out_if.ready = 1'b0;
        stall_left--;
      end else begin
        out_if.ready = 1'b1;
        if ($urandom_range(49) == 0) begin
          sink_burst = !sink_burst;
        end
        stall_left = idle_len(sink_burst);
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    hdr_result_t got;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got.status = status_e'(out_if.status);
      got.version_code = out_if.version_code;
      got.layer = out_if.layer;
      got.crc_bit = out_if.crc_bit;
      got.bitrate_kbps = out_if.bitrate_kbps;
      got.sample_rate_hz = out_if.sample_rate_hz;
      got.frame_bytes = out_if.frame_bytes;
      got.channel_mode = out_if.channel_mode;
      got.copyright_bit = out_if.copyright_bit;
      got.original_bit = out_if.original_bit;
      got.emphasis = out_if.emphasis;
      sb.check_result(got);
    end
  end

  initial begin
    #5_000_000;
    $display("mpeg_audio_frame_header_sync_unit verification failed");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/mafhs_pkg.sv
rtl/core/mafhs_in_if.sv
rtl/core/mafhs_out_if.sv
rtl/core/mafhs_front.sv
rtl/core/mafhs_fifo.sv
rtl/core/mafhs_back.sv
rtl/core/mpeg_audio_frame_header_sync_unit.sv
tb/sv/mpeg_audio_frame_header_sync_unit_tb.sv
